FILE: hw/rtl/ccbr_pkg.sv
// ----------------------------------------------------------------------------
// ccbr_pkg: shared types and constants for the console byte router
// Request and result payload structs, configuration bundle, event codes,
// special byte values, deframer phase encoding, register indexes and reset values.
// ----------------------------------------------------------------------------
package ccbr_pkg;

	// Request payload: one received byte and its arrival timestamp.
	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [47:0] arrival_time_us;
	} in_item_t;

	// Result payload: exactly one result per request.
	typedef struct packed {
		logic [3:0] event_res;
		logic [7:0] data_byte;
		logic [8:0] count;
		logic       in_packet_mode;
		logic       line_timed_out;
	} out_item_t;

	// Timeout registers as seen by the datapath.
	typedef struct packed {
		logic [31:0] line_idle_timeout_us;
		logic [31:0] packet_idle_timeout_us;
	} cfg_t;

	// Register indexes on the configuration port.
	localparam logic [0:0] REG_LINE_IDLE   = 1'b0;
	localparam logic [0:0] REG_PACKET_IDLE = 1'b1;

	// Register reset values.
	localparam logic [31:0] LINE_IDLE_RESET   = 32'd600000000;
	localparam logic [31:0] PACKET_IDLE_RESET = 32'd500000;

	// Event codes.
	localparam logic [3:0] EV_IGNORED     = 4'd0;
	localparam logic [3:0] EV_ECHO        = 4'd1;
	localparam logic [3:0] EV_ESC_CLEAR   = 4'd2;
	localparam logic [3:0] EV_EMPTY_LINE  = 4'd3;
	localparam logic [3:0] EV_COMMAND     = 4'd4;
	localparam logic [3:0] EV_LINE_OVF    = 4'd5;
	localparam logic [3:0] EV_PACKET_MODE = 4'd6;
	localparam logic [3:0] EV_FRAME_BYTE  = 4'd7;
	localparam logic [3:0] EV_FRAME_END   = 4'd8;
	localparam logic [3:0] EV_FRAME_OVF   = 4'd9;

	// Special byte values.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;

	// Deframer phases.
	typedef enum logic [2:0] {
		PH_WAIT_ZERO    = 3'b001,
		PH_WAIT_NONZERO = 3'b010,
		PH_RECEIVING    = 3'b100
	} phase_t;

endpackage

FILE: hw/rtl/ccbr_cfg_regs.sv
// ----------------------------------------------------------------------------
// ccbr_cfg_regs: timeout configuration registers
// Holds the line and packet idle timeouts, written through a plain write port.
// ----------------------------------------------------------------------------
module ccbr_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [0:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output ccbr_pkg::cfg_t       cfg
);
	import ccbr_pkg::*;

	logic [31:0] line_idle_q;
	logic [31:0] packet_idle_q;

	// Decode the register index on each write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_idle_q   <= LINE_IDLE_RESET;
			packet_idle_q <= PACKET_IDLE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINE_IDLE:   line_idle_q   <= cfg_data;
				REG_PACKET_IDLE: packet_idle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.line_idle_timeout_us   = line_idle_q;
	assign cfg.packet_idle_timeout_us = packet_idle_q;

endmodule

FILE: hw/rtl/ccbr_step.sv
// ----------------------------------------------------------------------------
// ccbr_step: router state and single-pass byte decision
// Holds mode, deframer phase, line and frame lengths and the last arrival
// time; computes the result of one byte and commits the new state on advance.
// ----------------------------------------------------------------------------
module ccbr_step #(
	parameter int LINE_BYTES  = 129,
	parameter int FRAME_BYTES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccbr_pkg::cfg_t       cfg,
	input  ccbr_pkg::in_item_t   item,
	input  logic                 advance,
	output ccbr_pkg::out_item_t  result
);
	import ccbr_pkg::*;

	localparam logic [7:0] LINE_MAX  = 8'(LINE_BYTES);
	localparam logic [8:0] FRAME_MAX = 9'(FRAME_BYTES);

	logic        packet_mode_q;
	phase_t      phase_q;
	logic [7:0]  line_len_q;
	logic [8:0]  frame_len_q;
	logic [47:0] last_arrival_q;

	logic        packet_mode_d;
	phase_t      phase_d;
	logic [7:0]  line_len_d;
	logic [8:0]  frame_len_d;

	logic [47:0] gap;
	logic        gap_gt_line;
	logic        gap_gt_packet;
	logic        line_to;
	logic        mode_eff;
	logic [7:0]  line_eff;
	logic [7:0]  b;
	phase_t      ph;

	// Idle gap since the previous byte, modulo 2^48, against the timeouts.
	assign gap           = item.arrival_time_us - last_arrival_q;
	assign gap_gt_line   = (gap[47:32] != 16'd0) || (gap[31:0] > cfg.line_idle_timeout_us);
	assign gap_gt_packet = (gap[47:32] != 16'd0) || (gap[31:0] > cfg.packet_idle_timeout_us);
	assign line_to       = !packet_mode_q && gap_gt_line;
	assign mode_eff      = packet_mode_q && !gap_gt_packet;
	assign line_eff      = line_to ? 8'd0 : line_len_q;
	assign b             = item.rx_byte;

	// Byte decision for both modes.
	always_comb begin
		packet_mode_d         = mode_eff;
		phase_d               = phase_q;
		line_len_d            = line_eff;
		frame_len_d           = frame_len_q;
		ph                    = PH_WAIT_ZERO;
		result.event_res      = EV_IGNORED;
		result.data_byte      = 8'd0;
		result.count          = 9'd0;
		result.line_timed_out = line_to;

		if (!mode_eff) begin
			// Interactive command line editing.
			if (b == CH_NUL) begin
				packet_mode_d    = 1'b1;
				phase_d          = PH_WAIT_NONZERO;
				result.event_res = EV_PACKET_MODE;
			end else if (b == CH_ESC) begin
				line_len_d       = 8'd0;
				result.event_res = EV_ESC_CLEAR;
			end else if (line_eff >= LINE_MAX) begin
				line_len_d       = 8'd0;
				result.event_res = EV_LINE_OVF;
			end else if (b == CH_LF || b == CH_CR) begin
				if (line_eff == 8'd0) begin
					result.event_res = EV_EMPTY_LINE;
				end else begin
					result.event_res = EV_COMMAND;
					result.count     = {1'b0, line_eff};
				end
				line_len_d = 8'd0;
			end else if (b >= CH_SPACE && b < CH_DEL) begin
				line_len_d       = line_eff + 8'd1;
				result.event_res = EV_ECHO;
				result.data_byte = b;
				result.count     = {1'b0, line_eff + 8'd1};
			end
		end else begin
			// Deframer: resolve the phase transitions before receiving.
			unique case (phase_q)
				PH_WAIT_NONZERO: begin
					if (b != CH_NUL) begin
						ph          = PH_RECEIVING;
						frame_len_d = 9'd0;
					end else begin
						ph = PH_WAIT_NONZERO;
					end
				end
				PH_RECEIVING: ph = PH_RECEIVING;
				default:      ph = (b == CH_NUL) ? PH_WAIT_NONZERO : PH_WAIT_ZERO;
			endcase

			if (ph == PH_RECEIVING) begin
				if (b == CH_NUL) begin
					result.event_res = EV_FRAME_END;
					result.count     = frame_len_d;
					ph               = PH_WAIT_NONZERO;
				end else if (frame_len_d >= FRAME_MAX) begin
					result.event_res = EV_FRAME_OVF;
					ph               = PH_WAIT_ZERO;
				end else begin
					frame_len_d      = frame_len_d + 9'd1;
					result.event_res = EV_FRAME_BYTE;
					result.data_byte = b;
					result.count     = frame_len_d;
				end
			end
			phase_d = ph;
		end

		result.in_packet_mode = packet_mode_d;
	end

	// Commit the state when the byte moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_mode_q  <= 1'b0;
			phase_q        <= PH_WAIT_ZERO;
			line_len_q     <= 8'd0;
			frame_len_q    <= 9'd0;
			last_arrival_q <= 48'd0;
		end else if (advance) begin
			packet_mode_q  <= packet_mode_d;
			phase_q        <= phase_d;
			line_len_q     <= line_len_d;
			frame_len_q    <= frame_len_d;
			last_arrival_q <= item.arrival_time_us;
		end
	end

endmodule

FILE: hw/rtl/console_cobs_byte_router.sv
// ----------------------------------------------------------------------------
// console_cobs_byte_router: console byte router with zero-delimited deframer
// Routes UART bytes either to a command line editor or to a frame deframer.
// ----------------------------------------------------------------------------
// Usage:
// A request carries one received byte and its 48-bit microsecond arrival
// time on in_valid/in_ready/in_data. Every request yields exactly one result
// on out_valid/out_ready/out_data, in order: the event code, the echoed or
// frame byte, the line or frame length, the mode after the byte and the line
// timeout flag. The timeouts are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write them only while no request is in flight, as the block
// itself does not enforce this. A request accepted into the input register
// moves into the result register, with the decision logic between, once
// that register is free or drains, and then shows on out_valid/out_data. The
// block takes one request per cycle while the receiver does not stall; the
// state is updated in the cycle the request moves into the result register,
// so back-to-back bytes see each other's updates directly.
// When the receiver stalls, the result register holds its item and the input
// register fills, then in_ready drops until out_ready returns.
// Reset clears both registers' valid flags, puts the block in interactive
// mode with an empty line, and loads the default timeouts.
// ----------------------------------------------------------------------------
module console_cobs_byte_router #(
	parameter int LINE_BYTES  = 129,
	parameter int FRAME_BYTES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ccbr_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ccbr_pkg::out_item_t  out_data,
	input  logic                 cfg_wr_en,
	input  logic [0:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import ccbr_pkg::*;

	cfg_t      cfg;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	out_item_t result;
	logic      advance;

	ccbr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ccbr_step #(
		.LINE_BYTES  (LINE_BYTES),
		.FRAME_BYTES (FRAME_BYTES)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	// The input stage moves on whenever the result register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for console_cobs_byte_router
// Drives received bytes with arrival times through the request channel and
// predicts every result with a cycle-free model of the line editor and the
// zero-delimited deframer. Directed checks cover the byte classes, timeouts
// and length limits; random command lines, frame sessions and noise follow
// under several timeout settings, sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
	import ccbr_pkg::*;

	localparam int LINE_LIMIT  = 129;
	localparam int FRAME_LIMIT = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_wr_en;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;

	// Predicted state of the router and its timeout registers.
	logic        in_packet;
	phase_t      deframe_ph;
	logic [7:0]  line_len;
	logic [8:0]  frame_len;
	logic [47:0] prev_arrival;
	logic [31:0] line_to_us;
	logic [31:0] pkt_to_us;

	// Stimulus and checking bookkeeping.
	out_item_t   expected_results[$];
	out_item_t   want_res;
	logic [47:0] now_us;
	int          sent_count;
	int          results_seen;
	int          mismatch_count;
	int          cycle_count;
	int          src_idle_pct;
	int          snk_stall_pct;
	logic        sink_hold;

	console_cobs_byte_router #(
		.LINE_BYTES (LINE_LIMIT),
		.FRAME_BYTES(FRAME_LIMIT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out the result of one request and advance the predicted state.
	function automatic out_item_t route_byte(input in_item_t req);
		out_item_t   res;
		logic [47:0] gap;
		logic [7:0]  b;
		res = '0;
		res.event_res = EV_IGNORED;
		b = req.rx_byte;
		gap = req.arrival_time_us - prev_arrival;

		// Idle gaps: clear a partial line, or drop out of packet mode.
		if (!in_packet) begin
			if (gap > {16'd0, line_to_us}) begin
				line_len = '0;
				res.line_timed_out = 1'b1;
			end
		end else if (gap > {16'd0, pkt_to_us}) begin
			in_packet = 1'b0;
		end

		if (!in_packet) begin
			if (b == CH_NUL) begin
				in_packet = 1'b1;
				deframe_ph = PH_WAIT_NONZERO;
				res.event_res = EV_PACKET_MODE;
			end else if (b == CH_ESC) begin
				line_len = '0;
				res.event_res = EV_ESC_CLEAR;
			end else if (line_len >= LINE_LIMIT) begin
				line_len = '0;
				res.event_res = EV_LINE_OVF;
			end else if (b == CH_LF || b == CH_CR) begin
				if (line_len == 0) begin
					res.event_res = EV_EMPTY_LINE;
				end else begin
					res.event_res = EV_COMMAND;
					res.count = 9'(line_len);
				end
				line_len = '0;
			end else if (b >= CH_SPACE && b < CH_DEL) begin
				line_len = line_len + 8'd1;
				res.event_res = EV_ECHO;
				res.data_byte = b;
				res.count = 9'(line_len);
			end
		end else begin
			// Deframer: any phase other than the two below waits for a zero.
			if (deframe_ph == PH_WAIT_NONZERO) begin
				if (b != CH_NUL) begin
					deframe_ph = PH_RECEIVING;
					frame_len = '0;
				end
			end else if (deframe_ph != PH_RECEIVING) begin
				if (b == CH_NUL) deframe_ph = PH_WAIT_NONZERO;
			end
			if (deframe_ph == PH_RECEIVING) begin
				if (b == CH_NUL) begin
					res.event_res = EV_FRAME_END;
					res.count = frame_len;
					deframe_ph = PH_WAIT_NONZERO;
				end else if (frame_len >= FRAME_LIMIT) begin
					res.event_res = EV_FRAME_OVF;
					deframe_ph = PH_WAIT_ZERO;
				end else begin
					frame_len = frame_len + 9'd1;
					res.event_res = EV_FRAME_BYTE;
					res.data_byte = b;
					res.count = frame_len;
				end
			end
		end

		prev_arrival = req.arrival_time_us;
		res.in_packet_mode = in_packet;
		return res;
	endfunction

	// Gap that triggers neither timeout under the current settings.
	function automatic logic [47:0] quiet_gap();
		logic [31:0] top;
		top = (line_to_us < pkt_to_us) ? line_to_us : pkt_to_us;
		if (top > 32'd1000) top = 32'd1000;
		return 48'($urandom_range(0, top));
	endfunction

	// Mostly a quiet gap; else one on or just past a timeout edge, or anywhere in the 48-bit range.
	function automatic logic [47:0] pick_gap();
		if ($urandom_range(0, 24) != 0) return quiet_gap();
		case ($urandom_range(0, 4))
			0: return {16'd0, line_to_us};
			1: return {16'd0, line_to_us} + 48'd1;
			2: return {16'd0, pkt_to_us};
			3: return {16'd0, pkt_to_us} + 48'd1;
			default: return {16'($urandom), $urandom};
		endcase
	endfunction

	// Mostly printable characters, with an occasional stray byte.
	function automatic logic [7:0] line_char();
		if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
		return 8'($urandom_range(CH_SPACE, CH_DEL - 8'd1));
	endfunction

	function automatic logic [7:0] frame_char();
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		$display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
	endtask

	// Offer one request and record its prediction once it is accepted.
	task automatic send_byte(input logic [7:0] b, input logic [47:0] gap);
		in_item_t req;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		now_us = now_us + gap;
		req.rx_byte = b;
		req.arrival_time_us = now_us;
		in_valid = 1'b1;
		in_data = req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(route_byte(req));
		sent_count++;
	endtask

	// Stop offering requests and let every outstanding result drain.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Called on a falling edge with the block idle.
	task automatic cfg_write(input logic [0:0] idx, input logic [31:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == REG_LINE_IDLE) line_to_us = val;
		else pkt_to_us = val;
	endtask

	task automatic set_timeouts(input logic [31:0] line_val, input logic [31:0] pkt_val);
		wait_idle();
		cfg_write(REG_LINE_IDLE, line_val);
		cfg_write(REG_PACKET_IDLE, pkt_val);
	endtask

	// Byte classes of the line editor under the reset timeouts.
	task automatic test_line_editing();
		send_byte(CH_SPACE, 48'd1);
		send_byte(CH_DEL - 8'd1, 48'd1);
		send_byte(CH_DEL, 48'd1);
		send_byte(8'hff, 48'd1);
		send_byte(8'h01, 48'd1);
		send_byte(CH_CR, 48'd1);
		send_byte(CH_LF, 48'd1);
		send_byte(8'h41, 48'd1);
		send_byte(CH_ESC, 48'd1);
		send_byte(CH_CR, 48'd1);
	endtask

	// Entering packet mode, zeros skipped before a frame, frame end.
	task automatic test_packet_deframing();
		send_byte(CH_NUL, 48'd1);
		send_byte(CH_NUL, 48'd1);
		send_byte(8'hff, 48'd1);
		send_byte(8'h01, 48'd1);
		send_byte(CH_NUL, 48'd1);
	endtask

	// Timeout edges, the extreme register values and timestamp wrap.
	task automatic test_idle_timeouts();
		set_timeouts(32'd100, 32'd50);
		// Leaving packet mode skips the line timeout check for that byte.
		send_byte(8'h42, 48'd200);
		send_byte(8'h43, 48'd100);
		send_byte(8'h44, 48'd101);
		send_byte(CH_NUL, 48'd0);
		send_byte(8'h45, 48'd50);

		set_timeouts(32'd0, 32'hffff_ffff);
		send_byte(8'h46, 48'hffff_ffff);
		send_byte(8'h47, 48'h1_0000_0000);
		send_byte(8'h48, 48'd0);
		send_byte(8'h49, 48'd1);

		set_timeouts(32'hffff_ffff, 32'd0);
		send_byte(CH_LF, 48'hffff_ffff_fff0);
		send_byte(CH_NUL, 48'h20);
		send_byte(8'h55, 48'd0);
		send_byte(8'h55, 48'd1);
	endtask

	// A full line followed by one more byte, then a frame past its limit.
	task automatic test_length_limits();
		logic [7:0] b;
		set_timeouts(32'hffff_ffff, 32'hffff_ffff);
		// A gap past both timeouts forces interactive mode with an empty line.
		send_byte(8'($urandom_range(CH_SPACE, CH_DEL - 8'd1)), 48'h1_0000_0000);
		repeat (LINE_LIMIT - 1)
			send_byte(8'($urandom_range(CH_SPACE, CH_DEL - 8'd1)), 48'($urandom_range(0, 1000)));
		do b = 8'($urandom_range(1, 255)); while (b == CH_ESC);
		send_byte(b, 48'($urandom_range(0, 1000)));
		send_byte(8'h61, 48'd3);

		send_byte(CH_NUL, 48'd3);
		repeat (FRAME_LIMIT + 2) send_byte(frame_char(), 48'($urandom_range(0, 1000)));
		send_byte(CH_NUL, 48'd3);
		send_byte(CH_NUL, 48'd3);
		send_byte(frame_char(), 48'd3);
		send_byte(CH_NUL, 48'd3);
	endtask

	// The receiver holds off while the sender keeps offering requests.
	task automatic test_backpressure();
		set_timeouts(LINE_IDLE_RESET, PACKET_IDLE_RESET);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		fork
			begin
				@(posedge clk);
				sink_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold = 1'b0;
			end
			begin
				repeat (24) send_byte(line_char(), quiet_gap());
			end
		join
	endtask

	// One random sequence: a command line, a frame session, noise or an
	// abandoned line that the idle timeout clears.
	task automatic random_sequence();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			repeat ($urandom_range(0, 12)) send_byte(line_char(), pick_gap());
			case ($urandom_range(0, 5))
				0: send_byte(CH_ESC, pick_gap());
				1, 2: send_byte(CH_LF, pick_gap());
				default: send_byte(CH_CR, pick_gap());
			endcase
		end else if (kind <= 6) begin
			send_byte(CH_NUL, pick_gap());
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 3) == 0) send_byte(CH_NUL, pick_gap());
				repeat ($urandom_range(1, 12)) send_byte(frame_char(), pick_gap());
				send_byte(CH_NUL, pick_gap());
			end
			send_byte(line_char(), {16'd0, pkt_to_us} + 48'd1 + 48'($urandom_range(0, 1000)));
		end else if (kind == 7) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), pick_gap());
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(line_char(), pick_gap());
			send_byte(line_char(), {16'd0, line_to_us} + 48'd1 + 48'($urandom_range(0, 1000)));
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input logic [31:0] line_val, input logic [31:0] pkt_val, input int n_items);
		int target;
		set_timeouts(line_val, pkt_val);
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		target = sent_count + n_items;
		while (sent_count < target) random_sequence();
	endtask

	// Receiver: random stalls, or a solid hold-off when requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = !sink_hold && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("unexpected result, event_res", 32'(out_data.event_res), 0);
			end else begin
				want_res = expected_results.pop_front();
				if (out_data.event_res !== want_res.event_res)
					flag_mismatch("event_res", 32'(out_data.event_res),
						32'(want_res.event_res));
				if (out_data.data_byte !== want_res.data_byte)
					flag_mismatch("data_byte", 32'(out_data.data_byte),
						32'(want_res.data_byte));
				if (out_data.count !== want_res.count)
					flag_mismatch("count", 32'(out_data.count), 32'(want_res.count));
				if (out_data.in_packet_mode !== want_res.in_packet_mode)
					flag_mismatch("in_packet_mode", 32'(out_data.in_packet_mode),
						32'(want_res.in_packet_mode));
				if (out_data.line_timed_out !== want_res.line_timed_out)
					flag_mismatch("line_timed_out", 32'(out_data.line_timed_out),
						32'(want_res.line_timed_out));
			end
			results_seen++;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("console_cobs_byte_router test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_LINE_IDLE;
		cfg_data = '0;
		sink_hold = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		now_us = '0;
		sent_count = 0;
		results_seen = 0;
		mismatch_count = 0;
		cycle_count = 0;
		in_packet = 1'b0;
		deframe_ph = PH_WAIT_ZERO;
		line_len = '0;
		frame_len = '0;
		prev_arrival = '0;
		line_to_us = LINE_IDLE_RESET;
		pkt_to_us = PACKET_IDLE_RESET;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_line_editing();
		test_packet_deframing();
		test_idle_timeouts();
		test_length_limits();
		test_backpressure();
		test_random_traffic(0, 0, LINE_IDLE_RESET, PACKET_IDLE_RESET, 50);
		test_random_traffic(75, 0, 32'd2000, 32'd700, 50);
		test_random_traffic(0, 75, 32'hffff_ffff, 32'd0, 50);
		test_random_traffic(36, 36, 32'd5, 32'hffff_ffff, 50);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("console_cobs_byte_router test passed");
		else
			$display("console_cobs_byte_router test failed");
		$finish;
	end

endmodule
